FILE: design/fqd_pkg.sv
// Shared types, widths and codes for the queue delay tracker.
package fqd_pkg;

  localparam int TIME_W         = 48;
  localparam int CNT_W          = 32;
  localparam int SUM_W          = 64;
  localparam int OCC_W          = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 48;
  localparam int RING_DEPTH_DEF = 64;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [OCC_W-1:0]  occ_t;

  localparam occ_t LIMIT_RESET = occ_t'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCESS_DELAY = 2'd0,
    CFG_SERVICE_TIME = 2'd1,
    CFG_PATH_DELAY   = 2'd2,
    CFG_QUEUE_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    time_t interarrival_gap;
  } in_item_t;

  typedef struct packed {
    logic  was_dropped;
    time_t queue_delay;
    time_t depart_time;
    occ_t  occupancy;
    occ_t  peak_occupancy;
    cnt_t  delivered_total;
    cnt_t  dropped_total;
    sum_t  queue_delay_total;
    sum_t  end_to_end_total;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;   // add gap to generation clock
    logic calc_arr;  // form arrival time, read ring head
    logic pop;       // retire ring head
    logic serve;     // pick service start and waiting time
    logic drop;      // count a drop
    logic finish;    // departure, ring write, counters
    logic lat;       // end-to-end total
    logic load_out;  // fill output register
  } fqd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_ok;    // ring non-empty and head departed by arrival
    logic full;      // occupancy at limit
    logic out_free;  // output register can take a result
  } fqd_sts_t;

endpackage

FILE: design/fqd_ifs.sv
// Valid/ready channel interfaces for input items and results.
interface fqd_in_if;
  import fqd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fqd_out_if;
  import fqd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/fqd_ctrl.sv
// Sequencer for one packet: arrival, purge loop, service, statistics, result.
module fqd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fqd_pkg::fqd_sts_t sts,
  output fqd_pkg::fqd_cmd_t cmd
);
  import fqd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ARR, S_POP, S_SVC, S_FIN, S_LAT, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.take_in  = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_ARR;
        end
      end
      S_ARR: begin
        cmd.calc_arr = 1'b1;
        state_nxt    = S_POP;
      end
      S_POP: begin
        if (sts.pop_ok) begin
          cmd.pop = 1'b1;
        end else begin
          state_nxt = S_SVC;
        end
      end
      S_SVC: begin
        if (sts.full) begin
          cmd.drop  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.serve = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_LAT;
      end
      S_LAT: begin
        cmd.lat   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          in_ready_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

FILE: design/fqd_dpath.sv
// Time arithmetic, departure ring, statistics and output register.
module fqd_dpath #(
  parameter int RING_DEPTH = fqd_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fqd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fqd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  fqd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fqd_pkg::out_item_t             out_data,
  input  fqd_pkg::fqd_cmd_t              cmd,
  output fqd_pkg::fqd_sts_t              sts
);
  import fqd_pkg::*;

  localparam int IW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int CMPW = (CW > OCC_W) ? CW : OCC_W;

  function automatic time_t time_add(time_t a, time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic sum_t sum_add(sum_t a, sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_next(logic [IW-1:0] i);
    return (i == IW'(RING_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  // configuration
  time_t access_r, service_r, path_r;
  occ_t  limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_r  <= '0;
      service_r <= '0;
      path_r    <= '0;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_ACCESS_DELAY: access_r  <= cfg_wdata[TIME_W-1:0];
        CFG_SERVICE_TIME: service_r <= cfg_wdata[TIME_W-1:0];
        CFG_PATH_DELAY:   path_r    <= cfg_wdata[TIME_W-1:0];
        CFG_QUEUE_LIMIT:  limit_r   <= cfg_wdata[OCC_W-1:0];
      endcase
    end
  end

  // departure ring
  time_t           ring_mem [RING_DEPTH];
  time_t           rd_r;
  logic [IW-1:0]   head_r, tail_r, rd_addr;
  logic [CW-1:0]   count_r, peak_r;

  time_t           gen_r, arrival_r, free_r, start_r, qdelay_r, depart_r;
  logic [TIME_W:0] e2e_r;
  cnt_t            acc_cnt_r, drop_cnt_r;
  sum_t            wait_sum_r, lat_sum_r;
  logic            dropped_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  time_t           depart_c;
  logic [CMPW-1:0] lim_c;
  logic [CW-1:0]   count_inc;

  assign rd_addr   = cmd.pop ? ring_next(head_r) : head_r;
  assign depart_c  = time_add(start_r, service_r);
  assign count_inc = count_r + CW'(1);

  always_ff @(posedge clk) begin
    rd_r <= ring_mem[rd_addr];
    if (cmd.finish) begin
      ring_mem[tail_r] <= depart_c;
    end
  end

  // limit clamped to 1..RING_DEPTH
  always_comb begin
    lim_c = CMPW'(limit_r);
    if (lim_c == '0) begin
      lim_c = CMPW'(1);
    end else if (lim_c > CMPW'(RING_DEPTH)) begin
      lim_c = CMPW'(RING_DEPTH);
    end
  end

  assign sts.pop_ok   = (count_r != '0) && (rd_r <= arrival_r);
  assign sts.full     = CMPW'(count_r) >= lim_c;
  assign sts.out_free = !out_valid_r || out_ready;

  // per-packet working registers
  always_ff @(posedge clk) begin
    if (cmd.calc_arr) begin
      arrival_r <= time_add(gen_r, access_r);
    end
    if (cmd.serve) begin
      dropped_r <= 1'b0;
      if (arrival_r > free_r) begin
        start_r  <= arrival_r;
        qdelay_r <= '0;
      end else begin
        start_r  <= free_r;
        qdelay_r <= free_r - arrival_r;
      end
    end
    if (cmd.drop) begin
      dropped_r <= 1'b1;
      qdelay_r  <= '0;
      depart_r  <= '0;
    end
    if (cmd.finish) begin
      depart_r <= depart_c;
      e2e_r    <= {1'b0, path_r} + {1'b0, qdelay_r};
    end
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r      <= '0;
      free_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      peak_r     <= '0;
      acc_cnt_r  <= '0;
      drop_cnt_r <= '0;
      wait_sum_r <= '0;
      lat_sum_r  <= '0;
    end else begin
      if (cmd.take_in) begin
        gen_r <= time_add(gen_r, in_data.interarrival_gap);
      end
      if (cmd.pop) begin
        head_r  <= ring_next(head_r);
        count_r <= count_r - CW'(1);
      end
      if (cmd.drop && (drop_cnt_r != '1)) begin
        drop_cnt_r <= drop_cnt_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        free_r     <= depart_c;
        tail_r     <= ring_next(tail_r);
        count_r    <= count_inc;
        if (count_inc > peak_r) begin
          peak_r <= count_inc;
        end
        if (acc_cnt_r != '1) begin
          acc_cnt_r <= acc_cnt_r + CNT_W'(1);
        end
        wait_sum_r <= sum_add(wait_sum_r, SUM_W'(qdelay_r));
      end
      if (cmd.lat) begin
        lat_sum_r <= sum_add(lat_sum_r, SUM_W'(e2e_r));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.was_dropped       <= dropped_r;
      out_data_r.queue_delay       <= qdelay_r;
      out_data_r.depart_time       <= depart_r;
      out_data_r.occupancy         <= OCC_W'(count_r);
      out_data_r.peak_occupancy    <= OCC_W'(peak_r);
      out_data_r.delivered_total   <= acc_cnt_r;
      out_data_r.dropped_total     <= drop_cnt_r;
      out_data_r.queue_delay_total <= wait_sum_r;
      out_data_r.end_to_end_total  <= lat_sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RING_DEPTH))
    else $error("ring occupancy above capacity");

  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r)
    else $error("peak occupancy below current occupancy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty ring");

  a_drop_keeps_ring: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |=> (count_r == $past(count_r)) && (tail_r == $past(tail_r)))
    else $error("dropped packet changed the ring");
`endif

endmodule

FILE: design/finite_fifo_queue_delay_tracker.sv
// Top level: router queue delay tracker with a finite departure FIFO.
// Sequence: arrival, a purge loop (one ring read per cycle) that retires each
//   stored departure made by the arrival time, service, then for an accepted
//   packet finish and end-to-end total, and the result load.
// Throughput: one packet at a time.
// Reset (rst_n, synchronous): clears clocks, ring pointers, occupancy, totals and
//   configuration; the departure ring itself is not cleared and needs no sweep.
module finite_fifo_queue_delay_tracker #(
  parameter int RING_DEPTH = fqd_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fqd_in_if.sink                         in_ch,
  fqd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fqd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fqd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fqd_pkg::*;

  fqd_cmd_t cmd;
  fqd_sts_t sts;
  logic     in_ready;

  // Controller: steps each packet through arrival, purge, service,
  // statistics and the result transfer.
  fqd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: saturating 48-bit time adds, the departure ring memory,
  // the saturating totals and the output register. The output register
  // lets the next input transfer happen while a result waits.
  fqd_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
